// ----- hdl/dkcl_pkg.sv -----
// Shared types and constants for the debounced keypad code lock.
// Depends on nothing; imported by debounced_keypad_code_lock.
`default_nettype none

package dkcl_pkg;

  localparam int NUM_BUTTONS    = 6;
  localparam int NUM_DIGIT_KEYS = 4;   // buttons 0..3 enter digits 1..4
  localparam int BTN_BACKSPACE  = 4;
  localparam int BTN_CONFIRM    = 5;

  localparam int DIGIT_W    = 2;
  localparam int DEBOUNCE_W = 16;
  localparam int CODE_W     = 32;
  localparam int LEN_W      = 5;
  localparam int TIMER_W    = 16;
  localparam int COUNT_W    = 5;       // digit_count field

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // Register reset values
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CODE_W-1:0]     CODE_RESET     = 32'd0;
  localparam logic [LEN_W-1:0]      LENGTH_RESET   = 5'd4;
  localparam logic [TIMER_W-1:0]    REJECT_RESET   = 16'd1000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEBOUNCE_TICKS,
    CFG_SECRET_CODE,
    CFG_SECRET_LENGTH,
    CFG_REJECT_TICKS
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VERDICT_NONE,
    VERDICT_OPENED,
    VERDICT_CLOSED,
    VERDICT_REJECTED
  } verdict_t;

  typedef enum logic [1:0] {
    LIGHT_OFF,
    LIGHT_GREEN,
    LIGHT_RED
  } light_t;

  // Result word, first field in the highest bits
  typedef struct packed {
    logic [1:0]             light_color;
    logic                   vault_is_open;
    logic [1:0]             verdict;
    logic [COUNT_W-1:0]     digit_count;
    logic [NUM_BUTTONS-1:0] press_mask;
  } result_t;

endpackage : dkcl_pkg

`default_nettype wire

// ----- hdl/debounced_keypad_code_lock.sv -----
// Debounced six-button keypad code lock, one tick item in, one result out.
// Depends on dkcl_pkg.
//
// Each transfer on the slave side is one tick of six raw active-low button
// levels; each produces exactly one result transfer on the master side.
// Throughput is one tick per clock: the whole tick (six debouncers, up to four
// digit appends, backspace, confirm compare) is evaluated in one pass between
// the input register and the result register, so each tick passes through both
// registers in turn. The block keeps accepting while a result waits,
// and only stalls when the input register and the result register both hold a
// tick and the result is not being taken. Configuration is written through
// cfg_we/cfg_index/cfg_data and should only change while no tick is in flight.
// A level must hold for more than debounce_ticks ticks to become stable; a
// stable fall counts as a press. Presses in one tick act in button order:
// digit keys, then backspace, then confirm. A wrong code shows red for
// reject_ticks results without blocking.
`default_nettype none

module debounced_keypad_code_lock #(
  parameter int MAX_DIGITS = 16,   // entry buffer depth, 1..16
  parameter int COUNT_BITS = 16    // hold counter width, 4..32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // slave side: [5:0] button_levels, [7:6] zero
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [dkcl_pkg::IN_TDATA_W-1:0]     s_tdata,
  // master side: [5:0] press_mask, [10:6] digit_count, [12:11] verdict,
  // [13] vault_is_open, [15:14] light_color
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [dkcl_pkg::OUT_TDATA_W-1:0]         m_tdata,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [dkcl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [dkcl_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dkcl_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int CMP_W = (COUNT_BITS > DEBOUNCE_W) ? COUNT_BITS : DEBOUNCE_W;
  localparam logic [COUNT_BITS-1:0] HOLD_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers
  logic [DEBOUNCE_W-1:0] debounce_ticks;
  logic [CODE_W-1:0]     lock_code;
  logic [LEN_W-1:0]      secret_length;
  logic [TIMER_W-1:0]    reject_ticks;

  // Input register
  logic                   in_vld;
  logic [NUM_BUTTONS-1:0] in_levels;
  logic                   step;     // tick in the input register is processed

  // Debouncer state
  logic [NUM_BUTTONS-1:0] prev_raw;
  logic [NUM_BUTTONS-1:0] stable;
  logic [COUNT_BITS-1:0]  hold      [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] stable_next;
  logic [COUNT_BITS-1:0]  hold_next [NUM_BUTTONS];

  // Entry and lock state
  logic [DIGIT_W-1:0] digits      [MAX_DIGITS];
  logic [DIGIT_W-1:0] digits_next [MAX_DIGITS];
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   entry_count_next;
  logic               entry_overflow;
  logic               entry_overflow_next;
  logic               vault_open;
  logic               vault_open_next;
  light_t             light;
  light_t             light_next;
  logic [TIMER_W-1:0] red_timer;
  logic [TIMER_W-1:0] red_timer_next;

  logic [NUM_BUTTONS-1:0] press;
  logic                   match;
  verdict_t               verdict;
  result_t                result;

  // ---------------------------------------------------------------------------
  // Handshake: input register refills when empty or when its tick is processed;
  // processing happens whenever the result register is free or being drained.
  // ---------------------------------------------------------------------------
  assign step     = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_levels <= s_tdata[NUM_BUTTONS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      lock_code      <= CODE_RESET;
      secret_length  <= LENGTH_RESET;
      reject_ticks   <= REJECT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data[DEBOUNCE_W-1:0];
        CFG_SECRET_CODE:    lock_code      <= cfg_data[CODE_W-1:0];
        CFG_SECRET_LENGTH:  secret_length  <= cfg_data[LEN_W-1:0];
        CFG_REJECT_TICKS:   reject_ticks   <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // One tick, single pass
  // ---------------------------------------------------------------------------
  always_comb begin
    // debouncers, independent per button
    press       = '0;
    stable_next = stable;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (in_levels[i] != prev_raw[i]) begin
        hold_next[i] = '0;
      end else if (hold[i] != HOLD_MAX) begin
        hold_next[i] = hold[i] + COUNT_BITS'(1);
      end else begin
        hold_next[i] = hold[i];
      end
      if ((CMP_W'(hold_next[i]) > CMP_W'(debounce_ticks)) && (in_levels[i] != stable[i])) begin
        stable_next[i] = in_levels[i];
        press[i]       = !in_levels[i];
      end
    end

    // red timer runs down at the start of the tick
    red_timer_next = red_timer;
    light_next     = light;
    if (red_timer != '0) begin
      red_timer_next = red_timer - TIMER_W'(1);
      if (red_timer_next == '0 && light == LIGHT_RED) begin
        light_next = LIGHT_OFF;
      end
    end

    // digit keys in button order
    digits_next         = digits;
    entry_count_next    = entry_count;
    entry_overflow_next = entry_overflow;
    for (int b = 0; b < NUM_DIGIT_KEYS; b++) begin
      if (press[b]) begin
        if (entry_count_next < CNT_W'(MAX_DIGITS)) begin
          for (int k = 0; k < MAX_DIGITS; k++) begin
            if (entry_count_next == CNT_W'(k)) begin
              digits_next[k] = DIGIT_W'(b);
            end
          end
          entry_count_next = entry_count_next + CNT_W'(1);
        end else begin
          entry_overflow_next = 1'b1;
        end
      end
    end

    // backspace
    if (press[BTN_BACKSPACE] && entry_count_next != '0) begin
      entry_count_next = entry_count_next - CNT_W'(1);
    end

    // code compare on the entry as it stands after digits and backspace
    match = !entry_overflow_next && (LEN_W'(entry_count_next) == secret_length);
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if ((CNT_W'(k) < entry_count_next) &&
          (digits_next[k] != lock_code[DIGIT_W*k +: DIGIT_W])) begin
        match = 1'b0;
      end
    end

    // confirm
    verdict         = VERDICT_NONE;
    vault_open_next = vault_open;
    if (press[BTN_CONFIRM] && entry_count_next != '0) begin
      if (match) begin
        red_timer_next = '0;
        if (!vault_open) begin
          vault_open_next = 1'b1;
          light_next      = LIGHT_GREEN;
          verdict         = VERDICT_OPENED;
        end else begin
          vault_open_next = 1'b0;
          light_next      = LIGHT_OFF;
          verdict         = VERDICT_CLOSED;
        end
      end else begin
        red_timer_next = reject_ticks;
        light_next     = (reject_ticks != '0) ? LIGHT_RED : LIGHT_OFF;
        verdict        = VERDICT_REJECTED;
      end
      entry_count_next    = '0;
      entry_overflow_next = 1'b0;
    end

    result.press_mask    = press;
    result.digit_count   = COUNT_W'(entry_count_next);
    result.verdict       = verdict;
    result.vault_is_open = vault_open_next;
    result.light_color   = light_next;
  end

  // ---------------------------------------------------------------------------
  // State update
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw       <= '1;
      stable         <= '1;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        hold[i] <= '0;
      end
      entry_count    <= '0;
      entry_overflow <= 1'b0;
      vault_open     <= 1'b0;
      light          <= LIGHT_OFF;
      red_timer      <= '0;
    end else if (step) begin
      prev_raw       <= in_levels;
      stable         <= stable_next;
      hold           <= hold_next;
      entry_count    <= entry_count_next;
      entry_overflow <= entry_overflow_next;
      vault_open     <= vault_open_next;
      light          <= light_next;
      red_timer      <= red_timer_next;
    end
  end

  // entry buffer payload, no reset: only slots below the count are read
  always_ff @(posedge clk) begin
    if (step) begin
      digits <= digits_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (step) begin
      m_tdata <= result;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_DIGITS))
    else $error("entry count beyond buffer depth");

  a_red_needs_timer: assert property (@(posedge clk) disable iff (rst)
    (light == LIGHT_RED) |-> (red_timer != '0))
    else $error("red light with expired timer");

  a_open_green: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[12:11] == VERDICT_OPENED) |->
      (m_tdata[13] && m_tdata[15:14] == LIGHT_GREEN))
    else $error("vault opened without green light");

  a_confirm_clears: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[12:11] != VERDICT_NONE) |-> (m_tdata[10:6] == '0))
    else $error("entry not cleared after confirm");

  a_step_fills: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("processed tick lost its result");

endmodule : debounced_keypad_code_lock

`default_nettype wire

// ----- sim/debounced_keypad_code_lock_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for debounced_keypad_code_lock: drives button ticks, predicts every
// result with a cycle-free model of the debouncers and the code lock, checks each transfer.
// Depends on dkcl_pkg and the debounced_keypad_code_lock RTL only.

module debounced_keypad_code_lock_tb;
  import dkcl_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int ENTRY_DEPTH    = 16;
  localparam int HOLD_W         = 16;
  localparam int SETTLE_CYCLES  = 4;        // input and result registers plus margin
  localparam int TIMEOUT_CYCLES = 400_000;
  localparam int MAX_REPORTS    = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;     // [5:0] button_levels, [7:6] zero
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;           // [5:0] press_mask, [10:6] digit_count,
                                             // [12:11] verdict, [13] vault_is_open,
                                             // [15:14] light_color
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  debounced_keypad_code_lock #(
    .MAX_DIGITS(ENTRY_DEPTH),
    .COUNT_BITS(HOLD_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Lock model: its own copy of the registers and of the keypad state
  // ---------------------------------------------------------------------------
  logic [DEBOUNCE_W-1:0]  debounce_cfg;
  logic [CODE_W-1:0]      code_cfg;
  logic [LEN_W-1:0]       length_cfg;
  logic [TIMER_W-1:0]     reject_cfg;

  logic [NUM_BUTTONS-1:0] last_raw;
  logic [NUM_BUTTONS-1:0] settled;
  logic [HOLD_W-1:0]      hold_cnt [NUM_BUTTONS];
  logic [DIGIT_W-1:0]     entered  [ENTRY_DEPTH];
  int                     entered_n;
  bit                     overflowed;
  bit                     vault_open;
  light_t                 light;
  logic [TIMER_W-1:0]     red_left;

  result_t     lock_results[$];   // results still owed by the block, oldest first
  int unsigned ticks_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned opened_seen, closed_seen, rejected_seen;

  int unsigned tx_idle_pct;       // chance per cycle that the sender holds back
  int unsigned rx_idle_pct;       // chance per cycle that the receiver holds back
  int unsigned rx_hold_left;      // long receiver hold-off, counted down below

  task automatic reset_lock_model();
    debounce_cfg = DEBOUNCE_RESET;
    code_cfg     = CODE_RESET;
    length_cfg   = LENGTH_RESET;
    reject_cfg   = REJECT_RESET;
    last_raw     = '1;
    settled      = '1;
    for (int b = 0; b < NUM_BUTTONS; b++) hold_cnt[b] = '0;
    entered_n    = 0;
    overflowed   = 1'b0;
    vault_open   = 1'b0;
    light        = LIGHT_OFF;
    red_left     = '0;
  endtask

  // One tick through the debouncers and the lock; returns the result it causes.
  function automatic result_t lock_tick(logic [NUM_BUTTONS-1:0] levels);
    result_t                r;
    verdict_t               verdict;
    logic [NUM_BUTTONS-1:0] press;
    bit                     hit;
    verdict = VERDICT_NONE;
    press   = '0;
    // red timer runs down at the start of the tick
    if (red_left != 0) begin
      red_left--;
      if (red_left == 0 && light == LIGHT_RED) light = LIGHT_OFF;
    end
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (levels[b] != last_raw[b]) hold_cnt[b] = '0;
      else if (hold_cnt[b] != '1) hold_cnt[b]++;
      if (hold_cnt[b] > debounce_cfg && levels[b] != settled[b]) begin
        settled[b] = levels[b];
        if (!levels[b]) begin
          press[b] = 1'b1;
          if (b < NUM_DIGIT_KEYS) begin
            if (entered_n < ENTRY_DEPTH) begin
              entered[entered_n] = DIGIT_W'(b);
              entered_n++;
            end else begin
              overflowed = 1'b1;
            end
          end else if (b == BTN_BACKSPACE) begin
            if (entered_n > 0) entered_n--;
          end else if (entered_n > 0) begin
            // confirm: count and every digit must agree, no overflow pending
            hit = !overflowed && entered_n == int'(length_cfg);
            for (int k = 0; k < entered_n; k++)
              if (entered[k] != code_cfg[2*k +: 2]) hit = 1'b0;
            if (hit) begin
              red_left = '0;
              if (!vault_open) begin
                vault_open = 1'b1;
                light      = LIGHT_GREEN;
                verdict    = VERDICT_OPENED;
              end else begin
                vault_open = 1'b0;
                light      = LIGHT_OFF;
                verdict    = VERDICT_CLOSED;
              end
            end else begin
              red_left = reject_cfg;
              light    = (reject_cfg != 0) ? LIGHT_RED : LIGHT_OFF;
              verdict  = VERDICT_REJECTED;
            end
            entered_n  = 0;
            overflowed = 1'b0;
          end
        end
      end
      last_raw[b] = levels[b];
    end
    r.press_mask    = press;
    r.digit_count   = COUNT_W'(entered_n);
    r.verdict       = verdict;
    r.vault_is_open = vault_open;
    r.light_color   = light;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < MAX_REPORTS)
      $display("ERROR %0t ns: %s got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // receiver: random stalls, plus the long hold-off when one is requested
  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      m_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // checks each result transfer against the oldest prediction
  always @(posedge clk) begin : check_results
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (lock_results.size() == 0) begin
        report_mismatch("result with nothing owed, tdata", 32'(got), 0);
      end else begin
        want = lock_results.pop_front();
        results_checked++;
        if (got.press_mask !== want.press_mask)
          report_mismatch("press_mask", 32'(got.press_mask), 32'(want.press_mask));
        if (got.digit_count !== want.digit_count)
          report_mismatch("digit_count", 32'(got.digit_count), 32'(want.digit_count));
        if (got.verdict !== want.verdict)
          report_mismatch("verdict", 32'(got.verdict), 32'(want.verdict));
        if (got.vault_is_open !== want.vault_is_open)
          report_mismatch("vault_is_open", 32'(got.vault_is_open),
                          32'(want.vault_is_open));
        if (got.light_color !== want.light_color)
          report_mismatch("light_color", 32'(got.light_color), 32'(want.light_color));
        case (verdict_t'(want.verdict))
          VERDICT_OPENED:   opened_seen++;
          VERDICT_CLOSED:   closed_seen++;
          VERDICT_REJECTED: rejected_seen++;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tick side
  // ---------------------------------------------------------------------------
  function automatic logic [NUM_BUTTONS-1:0] key_bit(int b);
    return NUM_BUTTONS'(1) << b;
  endfunction

  // Offers one tick and returns at the edge where it transfers; valid is left high.
  task automatic send_tick(logic [NUM_BUTTONS-1:0] levels);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(levels);
    do @(posedge clk); while (!s_tready);
    lock_results.push_back(lock_tick(levels));
    ticks_sent++;
  endtask

  task automatic hold_levels(logic [NUM_BUTTONS-1:0] levels, int n);
    repeat (n) send_tick(levels);
  endtask

  // Press the buttons in mask long enough to register, then release until stable.
  task automatic tap(logic [NUM_BUTTONS-1:0] mask);
    hold_levels(~mask, int'(debounce_cfg) + 2);
    hold_levels('1, int'(debounce_cfg) + 2);
  endtask

  // Stops offering and waits until the block has delivered every owed result.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (lock_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DEBOUNCE_TICKS: debounce_cfg = value[DEBOUNCE_W-1:0];
      CFG_SECRET_CODE:    code_cfg     = value[CODE_W-1:0];
      CFG_SECRET_LENGTH:  length_cfg   = value[LEN_W-1:0];
      CFG_REJECT_TICKS:   reject_cfg   = value[TIMER_W-1:0];
      default: ;
    endcase
  endtask

  // registers only change with nothing in flight
  task automatic apply_settings(int unsigned debounce, logic [CODE_W-1:0] code,
                                int unsigned length, int unsigned reject);
    drain_results();
    write_reg(CFG_DEBOUNCE_TICKS, debounce);
    write_reg(CFG_SECRET_CODE, code);
    write_reg(CFG_SECRET_LENGTH, length);
    write_reg(CFG_REJECT_TICKS, reject);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // reset registers: a 50-tick debounce, so nothing registers yet
  task automatic test_reset_state();
    send_tick('1);
    send_tick('0);
  endtask

  // secret is digits 2,4; several buttons share ticks to hit the button ordering
  task automatic test_directed_sequences();
    apply_settings(0, 32'hFFFF_FFFD, 2, 3);
    tap(key_bit(BTN_CONFIRM));                                // confirm on empty entry
    tap(key_bit(1) | key_bit(3));                             // two digits in one tick
    tap(key_bit(BTN_CONFIRM));                                // match: opens, green
    tap(key_bit(1) | key_bit(3) | key_bit(BTN_CONFIRM));      // digits then confirm: closes
    tap(key_bit(0) | key_bit(BTN_CONFIRM));                   // wrong code: red for 3
    tap('1);            // all six: four digits, backspace, too-long reject
    tap(key_bit(1) | key_bit(3) | key_bit(BTN_CONFIRM));      // match: opens, green
  endtask

  // sixteen-digit secret of all fours; then overflow, which survives backspaces
  task automatic test_full_buffer();
    apply_settings(0, 32'hFFFF_FFFF, ENTRY_DEPTH, 0);
    repeat (ENTRY_DEPTH) tap(key_bit(3));
    tap(key_bit(BTN_CONFIRM));
    repeat (ENTRY_DEPTH + 1) tap(key_bit(3));
    repeat (2) tap(key_bit(BTN_BACKSPACE));
    repeat (2) tap(key_bit(3));
    tap(key_bit(BTN_CONFIRM));                                // reject with no red at all
  endtask

  // mostly well-formed entries with random content, the rest noise and odd presses
  task automatic test_random_entries(int unsigned n_ticks);
    int unsigned first_tick;
    int unsigned pick;
    int unsigned n;
    first_tick = ticks_sent;
    while (ticks_sent - first_tick < n_ticks) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // the right code, now and then with a wrong digit taken back
        for (int k = 0; k < int'(length_cfg); k++) begin
          if ($urandom_range(9) == 0) begin
            tap(key_bit($urandom_range(NUM_DIGIT_KEYS - 1)));
            tap(key_bit(BTN_BACKSPACE));
          end
          tap(key_bit(code_cfg[2*k +: 2]));
        end
        tap(key_bit(BTN_CONFIRM));
      end else if (pick < 60) begin
        n = $urandom_range(1, int'(length_cfg) + 1);
        repeat (n) tap(key_bit($urandom_range(NUM_DIGIT_KEYS - 1)));
        tap(key_bit(BTN_CONFIRM));
      end else if (pick < 65) begin
        n = ENTRY_DEPTH + 1 + $urandom_range(2);
        repeat (n) tap(key_bit($urandom_range(NUM_DIGIT_KEYS - 1)));
        repeat ($urandom_range(3)) tap(key_bit(BTN_BACKSPACE));
        tap(key_bit(BTN_CONFIRM));
      end else if (pick < 80) begin
        // contact bounce: random levels, then a clean release
        repeat ($urandom_range(1, 6)) send_tick(NUM_BUTTONS'($urandom));
        hold_levels('1, int'(debounce_cfg) + 2);
      end else if (pick < 92) begin
        tap(NUM_BUTTONS'($urandom));
      end else begin
        tap(key_bit($urandom_range(BTN_BACKSPACE, BTN_CONFIRM)));
      end
    end
  endtask

  // a long debounce: raw activity never becomes stable within the run
  task automatic test_long_debounce();
    apply_settings(65534, $urandom, 2, 7);
    repeat (8) send_tick(NUM_BUTTONS'($urandom));
  endtask

  // receiver holds off for a long stretch while ticks keep coming
  task automatic test_output_backpressure();
    rx_hold_left = 300;
    test_random_entries(120);
  endtask

  initial begin
    ticks_sent      = 0;
    results_checked = 0;
    mismatches      = 0;
    opened_seen     = 0;
    closed_seen     = 0;
    rejected_seen   = 0;
    rx_hold_left    = 0;
    tx_idle_pct     = 10;
    rx_idle_pct     = 62;
    reset_lock_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_directed_sequences();
    test_full_buffer();
    apply_settings(0, $urandom, 3, 5);
    test_random_entries(330);

    tx_idle_pct = 62;
    rx_idle_pct = 10;
    apply_settings(1, $urandom, 1, 65535);
    test_random_entries(330);
    test_long_debounce();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_settings(3, 32'h0000_0000, 4, 1);
    test_random_entries(250);
    test_output_backpressure();

    drain_results();
    $display("Covered %0d ticks: directed entries, full buffer, long debounce, three random",
             ticks_sent);
    $display("phases with stalls and a long output hold-off; %0d results", results_checked);
    $display("(%0d open, %0d close, %0d reject)", opened_seen, closed_seen, rejected_seen);
    if (mismatches == 0) begin
      $display("debounced_keypad_code_lock: match");
    end else begin
      $display("debounced_keypad_code_lock: mismatch");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("TIMEOUT with %0d results still owed", lock_results.size());
    $display("debounced_keypad_code_lock: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/dkcl_pkg.sv
hdl/debounced_keypad_code_lock.sv
sim/debounced_keypad_code_lock_tb.sv
